>>> rtl/double_ended_queue_with_search_assert.svh
// Assertion macros used by the deque sequencer.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define DEQS_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define DEQS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define DEQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DEQS_ASSERT_HOLDS(label, clk, rst, cond, msg)
`define DEQS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define DEQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/deqs_pkg.sv
package deqs_pkg;

   // Capacity of the deque in entries.
   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   // Access request from the sequencer to the entry store.
   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [PTR_W-1:0]  rd_addr;
   } ram_req_type;

endpackage

>>> rtl/deqs_ram.sv
module deqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/deqs_seq.sv
`include "double_ended_queue_with_search_assert.svh"

module deqs_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [deqs_pkg::OP_W-1:0]           req_operation,
   input  logic [deqs_pkg::DATA_W-1:0]         req_value,
   output deqs_pkg::ram_req_type               ram_req,
   input  logic [deqs_pkg::DATA_W-1:0]         ram_rd_data,
   output logic                                rsp_valid,
   output logic [deqs_pkg::STAT_W-1:0]         rsp_status,
   output logic [deqs_pkg::DATA_W-1:0]         rsp_popped_value,
   output logic [deqs_pkg::CNT_W-1:0]          rsp_position,
   output logic [deqs_pkg::CNT_W-1:0]          rsp_occupancy
);

   localparam int PTR_W  = deqs_pkg::PTR_W;
   localparam int CNT_W  = deqs_pkg::CNT_W;
   localparam int DATA_W = deqs_pkg::DATA_W;
   localparam logic [PTR_W:0]   DEPTH_S  = (PTR_W + 1)'(deqs_pkg::DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(deqs_pkg::DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(deqs_pkg::DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_POP    = 4'b0100,
      S_SCAN   = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [deqs_pkg::OP_W-1:0]  op_ff, op_in;
   logic [DATA_W-1:0]          value_ff, value_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [PTR_W-1:0]           idx_ff, idx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [deqs_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]          rsp_popped_ff, rsp_popped_in;
   logic [CNT_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]           rsp_occ_ff, rsp_occ_in;

   logic [PTR_W:0]             slot_sum;
   logic [PTR_W-1:0]           slot;
   logic [PTR_W-1:0]           head_dec;
   logic [PTR_W-1:0]           head_inc;
   logic                       is_full;
   logic                       is_empty;
   logic                       hit;
   logic                       last_entry;
   logic [CNT_W-1:0]           count_dec;

   assign head_dec   = (head_ff == '0) ? LAST_PTR : head_ff - PTR_W'(1);
   assign head_inc   = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
   assign is_full    = (count_ff == FULL_CNT);
   assign is_empty   = (count_ff == '0);
   assign count_dec  = count_ff - CNT_W'(1);
   // Shared comparator over the registered read data.
   assign hit        = (ram_rd_data == value_ff);
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Sequence one item through decode, read and scan.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_pos_in    = rsp_pos_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_data = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               value_in = req_value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_status_in = deqs_pkg::ST_OK;
            rsp_popped_in = '0;
            rsp_pos_in    = '0;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
            unique case (op_ff) inside
               deqs_pkg::OP_PUSH_FRONT: begin
                  if (is_full) begin
                     rsp_status_in = deqs_pkg::ST_FULL;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     head_in         = head_dec;
                     count_in        = count_ff + CNT_W'(1);
                  end
               end
               deqs_pkg::OP_PUSH_REAR: begin
                  idx_in = count_ff[PTR_W-1:0];
                  if (is_full) begin
                     rsp_status_in = deqs_pkg::ST_FULL;
                  end else begin
                     ram_req.wr_en = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_REAR: begin
                  idx_in = (op_ff == deqs_pkg::OP_POP_FRONT) ? '0 : count_dec[PTR_W-1:0];
                  if (is_empty) begin
                     rsp_status_in = deqs_pkg::ST_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_POP;
                  end
               end
               deqs_pkg::OP_SEARCH: begin
                  idx_in = '0;
                  if (is_empty) begin
                     rsp_status_in = deqs_pkg::ST_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            // Drop the entry whose data is now on the read port.
            rsp_valid_in  = 1'b1;
            rsp_status_in = deqs_pkg::ST_OK;
            rsp_popped_in = ram_rd_data;
            rsp_pos_in    = '0;
            count_in      = count_dec;
            if (op_ff == deqs_pkg::OP_POP_FRONT) begin
               head_in = head_inc;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // Compare one entry per cycle, advance until hit or end.
            rsp_popped_in = '0;
            if (hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = deqs_pkg::ST_OK;
               rsp_pos_in    = CNT_W'(idx_ff) + CNT_W'(1);
               state_in      = S_IDLE;
            end else if (last_entry) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = deqs_pkg::ST_NOT_FOUND;
               rsp_pos_in    = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + PTR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Map the offset from the front to a buffer slot, wrapping once.
      slot_sum = {1'b0, head_ff} + {1'b0, idx_in};
      if (slot_sum >= DEPTH_S) begin
         slot_sum = slot_sum - DEPTH_S;
      end
      slot = slot_sum[PTR_W-1:0];

      ram_req.rd_addr = slot;
      ram_req.wr_addr = (op_ff == deqs_pkg::OP_PUSH_FRONT) ? head_dec : slot;
      rsp_occ_in      = rsp_valid_in ? count_in : rsp_occ_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Hold off items while a sequence runs and during reset.
   assign busy             = (state_ff != S_IDLE) || reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   `DEQS_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= FULL_CNT, "count above depth")
   `DEQS_ASSERT_NEXT(a_accept_decode, clock, reset,
      state_ff == S_IDLE && start, state_ff == S_DECODE, "accepted item not decoded")
   `DEQS_ASSERT_IMPLIES(a_strobe_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE,
      "result strobe while busy")
   `DEQS_ASSERT_IMPLIES(a_scan_range, clock, reset,
      state_ff == S_SCAN, CNT_W'(idx_ff) < count_ff, "scan index past last entry")

endmodule

>>> rtl/double_ended_queue_with_search.sv
// Bounded deque of signed 32-bit values with a search by value. Raise start
// with an operation while busy is low; exactly one result follows on the rsp_
// ports, marked by rsp_valid for a single cycle, and must be taken then since
// the block cannot be held off. A push, a refused operation or an unknown
// code is settled in the decode state; a pop goes on to a read state and a
// search to a scan state that compares up to DEPTH entries. The entry store
// has a single registered read port, and one comparator walks the entries
// from the front, one a cycle. busy drops in the cycle the strobe shows, so
// the next item may be accepted at the edge that ends it. busy also stays
// high while reset is asserted.
module double_ended_queue_with_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [deqs_pkg::OP_W-1:0]   req_operation,
   input  logic signed [deqs_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic [deqs_pkg::STAT_W-1:0] rsp_status,
   output logic signed [deqs_pkg::DATA_W-1:0] rsp_popped_value,
   output logic [deqs_pkg::CNT_W-1:0]  rsp_position,
   output logic [deqs_pkg::CNT_W-1:0]  rsp_occupancy
);

   deqs_pkg::ram_req_type             ram_req;
   logic [deqs_pkg::DATA_W-1:0]       ram_rd_data;
   logic [deqs_pkg::DATA_W-1:0]       popped_bits;

   // Sequencer with pointers, count and the shared comparator.
   deqs_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .ram_req          (ram_req),
      .ram_rd_data      (ram_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_value (popped_bits),
      .rsp_position     (rsp_position),
      .rsp_occupancy    (rsp_occupancy)
   );

   // Circular entry store.
   deqs_ram #(
      .WIDTH (deqs_pkg::DATA_W),
      .DEPTH (deqs_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_popped_value = signed'(popped_bits);

endmodule
